### rtl/oaid_pkg.sv
// Shared types, codes and widths for the ordered array insert/delete block.
package oaid_pkg;

  localparam int unsigned OAID_DEPTH     = 16;
  localparam int unsigned OAID_DEPTH_MAX = 64;
  localparam int unsigned CNT_W          = $clog2(OAID_DEPTH_MAX + 1);
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned POS_W          = 5;
  localparam int unsigned IDX_OUT_W      = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } oaid_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_REFUSED   = 2'd2,
    ST_EMPTY     = 2'd3
  } oaid_status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DUMP = 1'b1
  } oaid_fsm_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rot;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] last_idx;
    logic [CNT_W-1:0] count;
  } oaid_cmd_t;

endpackage

### rtl/oaid_cell.sv
// One storage cell of the ordered array chain: compare, shift and rotate.
module oaid_cell
  import oaid_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic              clk_i,
  input  oaid_cmd_t         cmd_i,
  input  logic [DATA_W-1:0] key_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  input  logic [DATA_W-1:0] head_i,
  input  logic              match_i,
  output logic              match_o,
  output logic              hit_o,
  output logic [DATA_W-1:0] val_o
);

  localparam logic [CNT_W-1:0] Idx = CNT_W'(CELL_IDX);

  logic [DATA_W-1:0] val_q, val_d;
  logic              occupied;
  logic              eq;

  assign occupied = Idx < cmd_i.count;
  assign eq       = occupied && (val_q == key_i);
  assign match_o  = match_i | eq;
  assign hit_o    = eq & ~match_i;
  assign val_o    = val_q;

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins) begin
      if (Idx == cmd_i.pos) begin
        val_d = key_i;
      end else if (Idx > cmd_i.pos) begin
        val_d = left_i;
      end
    end else if (cmd_i.del && (match_i || eq)) begin
      val_d = right_i;
    end else if (cmd_i.rot) begin
      // wrap the head around to the tail so a full pass restores order
      val_d = (Idx == cmd_i.last_idx) ? head_i : right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

### rtl/ordered_array_insert_delete.sv
// Top level of the ordered array: a chain of cells with insert, delete and dump.
// Timing: the output word is registered on acceptance for insert, delete, refusal and empty
//   dump; the first word of a dump follows the state register, then one a cycle unless stalled.
// Throughput: one item per cycle unless the output stalls, except dump, which holds the input
//   while the cell chain rotates its entries through cell zero.
// Reset: asynchronous, active low; clears count, sequencer and output valid, not the cells.
module ordered_array_insert_delete
  import oaid_pkg::*;
#(
  parameter int unsigned DEPTH = OAID_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[4:0], value[36:5], zero pad
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // element_value[31:0], element_index[35:32], zero pad
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  output logic        m_axis_tlast
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Input word fields
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_val;
  oaid_op_e          in_op;

  assign in_pos = s_axis_tdata[POS_W-1:0];
  assign in_val = s_axis_tdata[POS_W+DATA_W-1:POS_W];
  assign in_op  = oaid_op_e'(s_axis_tuser);

  // State
  oaid_fsm_e              state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [IW-1:0]          dcnt_q, dcnt_d;
  logic                   ovalid_q, ovalid_d;
  oaid_status_e           ostat_q, ostat_d;
  logic [DATA_W-1:0]      oval_q, oval_d;
  logic [IDX_OUT_W-1:0]   oidx_q, oidx_d;
  logic                   olast_q, olast_d;

  // Chain wiring
  oaid_cmd_t              cmd;
  logic [DATA_W-1:0]      cell_val [DEPTH];
  logic [DEPTH:0]         match;
  logic [DEPTH-1:0]       hit;
  logic [IW-1:0]          hit_idx;
  logic                   found;

  logic                   out_free;
  logic                   in_acc;
  logic [CNT_W-1:0]       cnt_ext;
  logic [CNT_W-1:0]       pos_ext;
  logic                   ins_ok;
  logic                   dump_last;

  assign out_free      = ~ovalid_q | m_axis_tready;
  assign s_axis_tready = (state_q == FSM_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign cnt_ext   = CNT_W'(count_q);
  assign pos_ext   = CNT_W'(in_pos);
  // refuse when full or when the position lies past the end
  assign ins_ok    = (cnt_ext < CNT_W'(DEPTH)) && (pos_ext <= cnt_ext);
  assign found     = match[DEPTH];
  assign dump_last = (CNT_W'(dcnt_q) == cmd.last_idx);

  // Drive the cell command
  always_comb begin
    cmd.ins      = in_acc && (in_op == OP_INSERT) && ins_ok;
    cmd.del      = in_acc && (in_op == OP_DELETE);
    cmd.rot      = (state_q == FSM_DUMP) && out_free;
    cmd.pos      = pos_ext;
    cmd.last_idx = cnt_ext - CNT_W'(1);
    cmd.count    = cnt_ext;
  end

  assign match[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = in_val;
    end else begin : g_mid
      assign left = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right = cell_val[0];
    end else begin : g_body
      assign right = cell_val[g+1];
    end
    oaid_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .key_i  (in_val),
      .left_i (left),
      .right_i(right),
      .head_i (cell_val[0]),
      .match_i(match[g]),
      .match_o(match[g+1]),
      .hit_o  (hit[g]),
      .val_o  (cell_val[g])
    );
  end

  // Encode the one-hot first match
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_idx = hit_idx | (hit[i] ? IW'(i) : '0);
    end
  end

  // Sequencer, count and output register
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    dcnt_d   = dcnt_q;
    ovalid_d = ovalid_q & ~m_axis_tready;
    ostat_d  = ostat_q;
    oval_d   = oval_q;
    oidx_d   = oidx_q;
    olast_d  = olast_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          ovalid_d = 1'b1;
          ostat_d  = ST_REFUSED;
          oval_d   = '0;
          oidx_d   = '0;
          olast_d  = 1'b1;
          case (in_op)
            OP_INSERT: begin
              if (ins_ok) begin
                ostat_d = ST_OK;
                oidx_d  = IDX_OUT_W'(in_pos);
                count_d = count_q + CW'(1);
              end
            end
            OP_DELETE: begin
              if (found) begin
                ostat_d = ST_OK;
                oidx_d  = IDX_OUT_W'(hit_idx);
                count_d = count_q - CW'(1);
              end else begin
                ostat_d = ST_NOT_FOUND;
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                ostat_d = ST_EMPTY;
              end else begin
                // hold the output empty and start the rotation
                ovalid_d = 1'b0;
                dcnt_d   = '0;
                state_d  = FSM_DUMP;
              end
            end
            default: begin
              ostat_d = ST_REFUSED;
            end
          endcase
        end
      end
      FSM_DUMP: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ostat_d  = ST_OK;
          oval_d   = cell_val[0];
          oidx_d   = IDX_OUT_W'(dcnt_q);
          olast_d  = dump_last;
          dcnt_d   = dcnt_q + IW'(1);
          if (dump_last) begin
            state_d = FSM_IDLE;
          end
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      count_q  <= '0;
      dcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      dcnt_q   <= dcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ostat_q <= ostat_d;
    oval_q  <= oval_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {{(40 - DATA_W - IDX_OUT_W){1'b0}}, oidx_q, oval_q};

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(count_q) <= CNT_W'(DEPTH))
    else $error("element count exceeds depth");

  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one first match");

  a_dump_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_DUMP) |-> !s_axis_tready)
    else $error("input accepted during dump");

  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == FSM_DUMP) && out_free && dump_last) |=>
      ((state_q == FSM_IDLE) && m_axis_tvalid && m_axis_tlast))
    else $error("dump did not end on last word");

endmodule
